>>> hdl/kdlr_pkg.sv
package kdlr_pkg;

  localparam int KEY_COUNT = 8;

  localparam logic [7:0]  FILTER_TICKS_RST = 8'd3;
  localparam logic [15:0] LONG_TICKS_RST   = 16'd100;
  localparam logic [15:0] REPEAT_TICKS_RST = 16'd10;

  typedef enum logic [1:0] {
    PH_DEBOUNCE = 2'd0,
    PH_PRESS    = 2'd1,
    PH_LONG     = 2'd2,
    PH_REPEAT   = 2'd3
  } phase_t;

  // register index within the config space (byte address / 4)
  typedef enum logic [1:0] {
    REG_FILTER_TICKS = 2'd0,
    REG_LONG_TICKS   = 2'd1,
    REG_REPEAT_TICKS = 2'd2,
    REG_SINGLE_KEY   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  filter_ticks;
    logic [15:0] long_ticks;
    logic [15:0] repeat_ticks;
    logic        single_key_mode;
  } cfg_t;

  typedef struct packed {
    logic repeat_hit;
    logic long_hit;
    logic tap_up;
    logic tap_down;
    logic released;
    logic down;
  } ev_t;

  localparam ev_t EV_RELEASED_ONLY = '{released: 1'b1, default: 1'b0};

endpackage

>>> hdl/kdlr_lane.sv
module kdlr_lane (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           pressed,
  input  logic           none_held,
  input  kdlr_pkg::cfg_t cfg,
  output kdlr_pkg::ev_t  ev,
  output kdlr_pkg::ev_t  ev_next
);

  kdlr_pkg::phase_t phase, phase_next;
  logic [7:0]  filter_count, filter_count_next;
  logic [15:0] hold_count, hold_count_next;
  logic [15:0] rpt_count, rpt_count_next;
  logic        press_valid, press_valid_next;

  logic [7:0]  filter_inc;
  logic [15:0] hold_inc;
  logic [15:0] repeat_inc;
  logic        gate;

  assign filter_inc = (filter_count == 8'hFF) ? filter_count : filter_count + 8'd1;
  assign hold_inc   = (hold_count == 16'hFFFF) ? hold_count : hold_count + 16'd1;
  assign repeat_inc = (rpt_count == 16'hFFFF) ? rpt_count : rpt_count + 16'd1;
  assign gate       = !cfg.single_key_mode || press_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= kdlr_pkg::PH_DEBOUNCE;
      filter_count <= '0;
      hold_count   <= '0;
      rpt_count    <= '0;
      ev           <= kdlr_pkg::EV_RELEASED_ONLY;
      press_valid  <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      filter_count <= filter_count_next;
      hold_count   <= hold_count_next;
      rpt_count    <= rpt_count_next;
      ev           <= ev_next;
      press_valid  <= press_valid_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    filter_count_next = filter_count;
    hold_count_next   = hold_count;
    rpt_count_next    = rpt_count;
    ev_next           = ev;
    press_valid_next  = press_valid;
    case (phase)
      kdlr_pkg::PH_DEBOUNCE: begin
        if (pressed) begin
          filter_count_next = filter_inc;
          if (filter_inc >= cfg.filter_ticks) begin
            phase_next        = kdlr_pkg::PH_PRESS;
            filter_count_next = cfg.filter_ticks;
            if (cfg.single_key_mode) begin
              press_valid_next = none_held;
            end
          end
        end else begin
          filter_count_next = '0;
          ev_next           = kdlr_pkg::EV_RELEASED_ONLY;
        end
        hold_count_next = '0;
        rpt_count_next  = '0;
      end
      kdlr_pkg::PH_PRESS: begin
        if (pressed) begin
          ev_next.released = 1'b0;
          if (gate) begin
            ev_next.down     = 1'b1;
            ev_next.tap_down = 1'b1;
          end
          phase_next = kdlr_pkg::PH_LONG;
        end else begin
          phase_next = kdlr_pkg::PH_DEBOUNCE;
        end
      end
      kdlr_pkg::PH_LONG: begin
        ev_next.tap_down = 1'b0;
        if (pressed) begin
          if (cfg.long_ticks != '0) begin
            hold_count_next = hold_inc;
            if (hold_inc >= cfg.long_ticks) begin
              ev_next.long_hit = 1'b1;
              phase_next       = kdlr_pkg::PH_REPEAT;
            end
          end
        end else begin
          ev_next.tap_up = 1'b1;
          phase_next     = kdlr_pkg::PH_DEBOUNCE;
        end
      end
      kdlr_pkg::PH_REPEAT: begin
        if (pressed) begin
          if (cfg.repeat_ticks != '0) begin
            rpt_count_next = repeat_inc;
            if (repeat_inc >= cfg.repeat_ticks) begin
              rpt_count_next = '0;
              if (gate) begin
                ev_next.repeat_hit = 1'b1;
              end
            end
          end
        end else begin
          phase_next = kdlr_pkg::PH_DEBOUNCE;
        end
      end
      default: begin
        phase_next = kdlr_pkg::PH_DEBOUNCE;
      end
    endcase
  end

endmodule

>>> hdl/kdlr_merge.sv
module kdlr_merge (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          result_stall,
  input  kdlr_pkg::ev_t lane_ev      [kdlr_pkg::KEY_COUNT],
  input  kdlr_pkg::ev_t lane_ev_next [kdlr_pkg::KEY_COUNT],
  output logic          none_held,
  output logic          result_valid,
  output logic [7:0]    down_flags,
  output logic [7:0]    released_flags,
  output logic [7:0]    click_down_flags,
  output logic [7:0]    click_up_flags,
  output logic [7:0]    long_flags,
  output logic [7:0]    repeat_flags
);

  logic [kdlr_pkg::KEY_COUNT-1:0] rel_now;
  logic [7:0] down_v, rel_v, cd_v, cu_v, long_v, rep_v;

  // pack lane flags into per-flag vectors; keys past bit 7 are not shown
  always_comb begin
    rel_now = '0;
    down_v  = '0;
    rel_v   = '0;
    cd_v    = '0;
    cu_v    = '0;
    long_v  = '0;
    rep_v   = '0;
    for (int k = 0; k < kdlr_pkg::KEY_COUNT; k++) begin
      rel_now[k] = lane_ev[k].released;
      if (k < 8) begin
        down_v[k] = lane_ev_next[k].down;
        rel_v[k]  = lane_ev_next[k].released;
        cd_v[k]   = lane_ev_next[k].tap_down;
        cu_v[k]   = lane_ev_next[k].tap_up;
        long_v[k] = lane_ev_next[k].long_hit;
        rep_v[k]  = lane_ev_next[k].repeat_hit;
      end
    end
  end

  assign none_held = &rel_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= advance || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      down_flags       <= down_v;
      released_flags   <= rel_v;
      click_down_flags <= cd_v;
      click_up_flags   <= cu_v;
      long_flags       <= long_v;
      repeat_flags     <= rep_v;
    end
  end

endmodule

>>> hdl/multi_key_debounce_long_repeat_core.sv
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+------------------------------------------
// item      | item_valid / item_stall     | key_level[7:0]
// result    | result_valid / result_stall | down, released, tap down, tap up,
//           |                             | long, repeat flag vectors (8 bits each)
// config    | APB write/read              | paddr[3:2] selects register, pwdata
//
// One scan tick per clock while no result sits stalled: each key has its
// own lane, all lanes step on the same transfer, and the merge stage
// registers the six flag vectors. result_valid rises in the cycle after
// an item transfer. The result register frees itself in the cycle it is
// taken, so item_stall only rises while a result sits stalled.
// rst is synchronous and active high; it puts every key in debounce with
// only its released flag set and restores the register defaults.
module multi_key_debounce_long_repeat_core (
  input  logic        clk,
  input  logic        rst,
  // scan ticks in
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  key_level,
  // flag vectors out
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  down_flags,
  output logic [7:0]  released_flags,
  output logic [7:0]  click_down_flags,
  output logic [7:0]  click_up_flags,
  output logic [7:0]  long_flags,
  output logic [7:0]  repeat_flags,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kdlr_pkg::cfg_t     cfg;
  kdlr_pkg::reg_idx_t reg_sel;
  logic               cfg_wr;
  logic               advance;
  logic               none_held;

  kdlr_pkg::ev_t lane_ev      [kdlr_pkg::KEY_COUNT];
  kdlr_pkg::ev_t lane_ev_next [kdlr_pkg::KEY_COUNT];

  // --- config registers ---
  assign pready  = 1'b1;
  assign reg_sel = kdlr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_ticks    <= kdlr_pkg::FILTER_TICKS_RST;
      cfg.long_ticks      <= kdlr_pkg::LONG_TICKS_RST;
      cfg.repeat_ticks    <= kdlr_pkg::REPEAT_TICKS_RST;
      cfg.single_key_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        kdlr_pkg::REG_FILTER_TICKS: cfg.filter_ticks    <= pwdata[7:0];
        kdlr_pkg::REG_LONG_TICKS:   cfg.long_ticks      <= pwdata[15:0];
        kdlr_pkg::REG_REPEAT_TICKS: cfg.repeat_ticks    <= pwdata[15:0];
        kdlr_pkg::REG_SINGLE_KEY:   cfg.single_key_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      kdlr_pkg::REG_FILTER_TICKS: prdata = {24'd0, cfg.filter_ticks};
      kdlr_pkg::REG_LONG_TICKS:   prdata = {16'd0, cfg.long_ticks};
      kdlr_pkg::REG_REPEAT_TICKS: prdata = {16'd0, cfg.repeat_ticks};
      kdlr_pkg::REG_SINGLE_KEY:   prdata = {31'd0, cfg.single_key_mode};
      default:                    prdata = '0;
    endcase
  end

  // --- transfer control ---
  // a new tick may enter whenever the result slot is empty or being emptied
  assign item_stall = result_valid && result_stall;
  assign advance    = item_valid && !item_stall;

  // --- per-key lanes ---
  for (genvar k = 0; k < kdlr_pkg::KEY_COUNT; k++) begin : g_lane
    logic key_bit;
    if (k < 8) begin : g_in
      assign key_bit = key_level[k];
    end else begin : g_none
      assign key_bit = 1'b0;
    end

    kdlr_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .pressed   (key_bit),
      .none_held (none_held),
      .cfg       (cfg),
      .ev        (lane_ev[k]),
      .ev_next   (lane_ev_next[k])
    );
  end

  // --- merge and result register ---
  // none_held comes from the flags at the start of the tick
  kdlr_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .result_stall     (result_stall),
    .lane_ev          (lane_ev),
    .lane_ev_next     (lane_ev_next),
    .none_held        (none_held),
    .result_valid     (result_valid),
    .down_flags       (down_flags),
    .released_flags   (released_flags),
    .click_down_flags (click_down_flags),
    .click_up_flags   (click_up_flags),
    .long_flags       (long_flags),
    .repeat_flags     (repeat_flags)
  );

endmodule

>>> hdl/kdlr_checker.sv
module kdlr_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  down_flags,
  input logic [7:0]  released_flags,
  input logic [7:0]  click_down_flags,
  input logic [7:0]  click_up_flags,
  input logic [7:0]  long_flags,
  input logic [7:0]  repeat_flags
);

  // stalled result holds down/released/long/repeat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(down_flags)
      && $stable(released_flags) && $stable(long_flags) && $stable(repeat_flags))
    else $error("stalled result changed");

  // every tick transfer yields a result next cycle
  a_tick: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("tick transfer lost");

  // a released key shows no press-side flags
  a_rel: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((down_flags | click_up_flags | long_flags | repeat_flags)
      & released_flags) == 8'd0)
    else $error("press flag with released");

  // tap-down only comes with down
  a_cd: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (click_down_flags & ~down_flags) == 8'd0)
    else $error("tap-down flag without down");

  a_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");

endmodule

bind multi_key_debounce_long_repeat_core kdlr_checker u_kdlr_checker (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item_valid),
  .item_stall       (item_stall),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .down_flags       (down_flags),
  .released_flags   (released_flags),
  .click_down_flags (click_down_flags),
  .click_up_flags   (click_up_flags),
  .long_flags       (long_flags),
  .repeat_flags     (repeat_flags)
);
